// ===== hw/rtl/ses_pkg.sv =====
// ses_pkg: shared types and character constants for the string escape stream.
// No dependencies; imported by ses_decode, ses_serial and string_escape_stream.
package ses_pkg;

   localparam logic [7:0] CHR_X     = 8'h78;  // 'x'
   localparam logic [7:0] CHR_B     = 8'h62;  // 'b'
   localparam logic [7:0] CHR_T     = 8'h74;  // 't'
   localparam logic [7:0] CHR_N     = 8'h6e;  // 'n'
   localparam logic [7:0] CHR_F     = 8'h66;  // 'f'
   localparam logic [7:0] CHR_R     = 8'h72;  // 'r'
   localparam logic [7:0] CHR_SQUOTE = 8'h27; // '\''
   localparam logic [7:0] CHR_DQUOTE = 8'h22; // '"'

   localparam logic [7:0] CTL_BS = 8'h08;
   localparam logic [7:0] CTL_HT = 8'h09;
   localparam logic [7:0] CTL_LF = 8'h0a;
   localparam logic [7:0] CTL_FF = 8'h0c;
   localparam logic [7:0] CTL_CR = 8'h0d;

   localparam logic [7:0] DELIM_RESET = 8'd34;
   localparam logic [7:0] ESC_RESET   = 8'd92;

   localparam int unsigned MAX_OUT = 4;

   typedef enum logic [0:0] {
      CSR_DELIMITER = 1'b0,
      CSR_ESCAPE    = 1'b1
   } csr_index_type;

   // one decoded source byte: up to four output bytes
   typedef struct packed {
      logic [MAX_OUT-1:0][7:0] bytes;
      logic [2:0]              count;     // 0 .. MAX_OUT
      logic                    str_last;
      logic                    pend_next;
   } dec_type;

endpackage

// ===== hw/rtl/ses_decode.sv =====
// ses_decode: turns one source byte plus the pending flag into its escaped bytes.
// Depends on ses_pkg.
module ses_decode
   import ses_pkg::*;
(
   input  logic [7:0] src_byte,
   input  logic       src_last,
   input  logic       pending,
   input  logic [7:0] delimiter,
   input  logic [7:0] escape_byte,
   output dec_type    dec
);

   logic [1:0]      pre_cnt;
   logic [1:0]      body_cnt;
   logic [1:0][7:0] body;
   logic            pend_set;
   logic [1:0]      j;

   always_comb begin
      // held escape from the previous byte comes out first, doubled unless 'x'
      if (pending) begin
         pre_cnt = (src_byte != CHR_X) ? 2'd2 : 2'd1;
      end else begin
         pre_cnt = 2'd0;
      end

      body     = {8'h00, src_byte};
      body_cnt = 2'd1;
      pend_set = 1'b0;
      case (src_byte)
         CTL_BS: begin body = {CHR_B, escape_byte}; body_cnt = 2'd2; end
         CTL_HT: begin body = {CHR_T, escape_byte}; body_cnt = 2'd2; end
         CTL_LF: begin body = {CHR_N, escape_byte}; body_cnt = 2'd2; end
         CTL_FF: begin body = {CHR_F, escape_byte}; body_cnt = 2'd2; end
         CTL_CR: begin body = {CHR_R, escape_byte}; body_cnt = 2'd2; end
         CHR_SQUOTE, CHR_DQUOTE: begin
            if (delimiter == src_byte || delimiter == 8'h00) begin
               body     = {src_byte, escape_byte};
               body_cnt = 2'd2;
            end
         end
         default: begin
            if (src_byte == escape_byte) begin
               if (src_last) begin
                  body = {escape_byte, escape_byte};
                  body_cnt = 2'd2;
               end else begin
                  body_cnt = 2'd0;
                  pend_set = 1'b1;
               end
            end
         end
      endcase
   end

   always_comb begin
      dec.count     = {1'b0, pre_cnt} + {1'b0, body_cnt};
      dec.str_last  = src_last;
      dec.pend_next = pend_set;
      for (int i = 0; i < MAX_OUT; i++) begin
         j = 2'(i) - pre_cnt;
         if (2'(i) < pre_cnt && i < 2) begin
            dec.bytes[i] = escape_byte;
         end else begin
            dec.bytes[i] = body[j[0]];
         end
      end
   end

endmodule

// ===== hw/rtl/ses_serial.sv =====
// ses_serial: result slot holding one decoded item, drained one byte per transfer.
// Depends on ses_pkg.
module ses_serial
   import ses_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  dec_type    dec,
   output logic       free,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tuser,
   output logic       rsp_tlast
);

   logic [MAX_OUT-1:0][7:0] bytes_ff;
   logic [2:0]              cnt_ff, cnt_in;
   logic [1:0]              idx_ff, idx_in;
   logic                    last_ff;
   logic                    final_byte;
   logic                    take;

   assign final_byte = ({1'b0, idx_ff} + 3'd1) == cnt_ff;
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = (cnt_ff == 3'd0) || (take && final_byte);

   assign rsp_tvalid = cnt_ff != 3'd0;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tuser  = final_byte;
   assign rsp_tlast  = final_byte && last_ff;

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = dec.count;
         idx_in = 2'd0;
      end else if (take) begin
         if (final_byte) begin
            cnt_in = 3'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= dec.bytes;
         last_ff  <= dec.str_last;
      end
   end

endmodule

// ===== hw/rtl/string_escape_stream.sv =====
// string_escape_stream: top level; input register, escape decode, result slot.
// Depends on ses_pkg, ses_decode and ses_serial.
//
//   channel  direction  signals                       content
//   req      in         req_tvalid/tready/tdata/tlast  source byte, end of string
//   rsp      out        rsp_tvalid/tready/tdata/tuser/tlast  escaped byte, ends
//   csr      in         csr_we/csr_addr/csr_wdata     delimiter, escape byte
//
// A source byte giving k output bytes holds the result slot until all k are
// taken; plain bytes stream at one per cycle while rsp_tready is high, escapes
// limit rate to the port. A byte passes the input register, then the result
// slot. Reset clears the pending escape, the valids and the registers
// to 34 and 92. A stalled rsp holds its byte and backs up into req_tready.
module string_escape_stream
   import ses_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] out_run_end
   output logic       rsp_tlast,   // out_string_end
   input  logic       csr_we,
   input  logic       csr_addr,
   input  logic [7:0] csr_wdata
);

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       pend_ff;
   logic [7:0] delim_ff;
   logic [7:0] esc_ff;
   logic       slot_free;
   logic       load;
   dec_type    dec;

   assign load       = in_vld_ff && slot_free;
   assign req_tready = !in_vld_ff || slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         pend_ff   <= 1'b0;
         delim_ff  <= DELIM_RESET;
         esc_ff    <= ESC_RESET;
      end else begin
         if (req_tready) begin
            in_vld_ff <= req_tvalid;
         end
         if (load) begin
            pend_ff <= dec.pend_next;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_DELIMITER: delim_ff <= csr_wdata;
               CSR_ESCAPE:    esc_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ses_decode u_decode (
      .src_byte    (in_byte_ff),
      .src_last    (in_last_ff),
      .pending     (pend_ff),
      .delimiter   (delim_ff),
      .escape_byte (esc_ff),
      .dec         (dec)
   );

   ses_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .dec        (dec),
      .free       (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/ses_checker.sv =====
// ses_checker: port-level checks on the escaped result stream.
// Bound to string_escape_stream; no package needed.
module ses_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   // a stalled transfer keeps its valid
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped under stall");

   // a stalled transfer keeps its byte
   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed under stall");

   // end of string is always also end of the run for that source byte
   a_str_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("string end without run end");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid straight after reset");

   // after reset, a byte must pass the input register and result slot before any output
   a_reset_lat: assert property (@(posedge clock) disable iff (reset)
      $past(reset, 2) && !$past(reset) |-> !rsp_tvalid)
      else $error("result valid too soon after reset");

endmodule

bind string_escape_stream ses_checker u_ses_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
